// ----- rtl/fpid_pkg.sv -----
package fpid_pkg;

    localparam int TEMP_W     = 13;
    localparam int GAIN_W     = 16;
    localparam int TIME_W     = 32;
    localparam int PWM_W      = 8;
    localparam int INTEG_W    = 22;
    localparam int DIFF_W     = TEMP_W + 1;
    localparam int PROD_W     = 52;
    localparam int ACC_W      = 52;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = TIME_W + 1;
    // Magnitude bits of the derivative numerator, kept even for two quotient bits a cycle.
    localparam int DIV_W      = 50;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 5;
    localparam int XS_W       = 15;
    localparam int SEL_W      = 3;
    localparam int ACC_OP_W   = 2;
    localparam int DP_OP_W    = 4;
    localparam int COND_W     = 3;

    // The duty is sum / 4096000, and 4096000 = 125 * 2^15.
    localparam int SCALE_SHIFT = 15;
    localparam int RECIP_SHIFT = 22;

    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 22'sd1600000;
    localparam logic signed [TEMP_W-1:0]  ERR_MAX     = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic signed [TEMP_W-1:0]  ERR_MIN     = {1'b1, {(TEMP_W-1){1'b0}}};
    localparam logic [PWM_W-1:0]          PWM_FULL    = 8'hFF;
    localparam logic [PWM_W-1:0]          PWM_OFF     = 8'h00;
    localparam logic [MUL_B_W-1:0]        K_MILLI     = 33'd1000;
    localparam logic [MUL_B_W-1:0]        K_MICRO     = 33'd1000000;
    localparam logic [MUL_B_W-1:0]        K_RECIP     = 33'd33555;
    localparam logic [ACC_W-SCALE_SHIFT-1:0] SCALED_FULL = 37'd32000;

    localparam logic [IDX_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CHG_THR   = 3'd4;
    localparam logic [IDX_W-1:0] REG_DIS_THR   = 3'd5;
    localparam logic [IDX_W-1:0] REG_CRIT_TEMP = 3'd6;

    typedef struct packed {
        logic signed [TEMP_W-1:0] target;
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_i;
        logic [GAIN_W-1:0]        gain_d;
        logic signed [TEMP_W-1:0] chg_thr;
        logic signed [TEMP_W-1:0] dis_thr;
        logic signed [TEMP_W-1:0] crit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        target:  13'sd560,
        gain_p:  16'd512,
        gain_i:  16'd128,
        gain_d:  16'd256,
        chg_thr: 13'sd640,
        dis_thr: 13'sd800,
        crit:    13'sd960
    };

    // Multiplier operand selects.
    localparam logic [SEL_W-1:0] ASEL_ERR   = 3'd0;
    localparam logic [SEL_W-1:0] ASEL_PROD  = 3'd1;
    localparam logic [SEL_W-1:0] ASEL_INTEG = 3'd2;
    localparam logic [SEL_W-1:0] ASEL_DIFF  = 3'd3;
    localparam logic [SEL_W-1:0] ASEL_XS    = 3'd4;

    localparam logic [SEL_W-1:0] BSEL_DT    = 3'd0;
    localparam logic [SEL_W-1:0] BSEL_GP    = 3'd1;
    localparam logic [SEL_W-1:0] BSEL_GI    = 3'd2;
    localparam logic [SEL_W-1:0] BSEL_GD    = 3'd3;
    localparam logic [SEL_W-1:0] BSEL_MILLI = 3'd4;
    localparam logic [SEL_W-1:0] BSEL_MICRO = 3'd5;
    localparam logic [SEL_W-1:0] BSEL_RECIP = 3'd6;

    localparam logic [ACC_OP_W-1:0] ACC_NONE = 2'd0;
    localparam logic [ACC_OP_W-1:0] ACC_LOAD = 2'd1;
    localparam logic [ACC_OP_W-1:0] ACC_ADD  = 2'd2;
    localparam logic [ACC_OP_W-1:0] ACC_ADDQ = 2'd3;

    localparam logic [DP_OP_W-1:0] DP_NOP   = 4'd0;
    localparam logic [DP_OP_W-1:0] DP_CRIT  = 4'd1;
    localparam logic [DP_OP_W-1:0] DP_THR   = 4'd2;
    localparam logic [DP_OP_W-1:0] DP_ERR   = 4'd3;
    localparam logic [DP_OP_W-1:0] DP_INTEG = 4'd4;
    localparam logic [DP_OP_W-1:0] DP_DIFF  = 4'd5;
    localparam logic [DP_OP_W-1:0] DP_DIVGO = 4'd6;
    localparam logic [DP_OP_W-1:0] DP_SCALE = 4'd7;
    localparam logic [DP_OP_W-1:0] DP_PWM   = 4'd8;

    localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] C_NO_IN    = 3'd2;
    localparam logic [COND_W-1:0] C_CRIT     = 3'd3;
    localparam logic [COND_W-1:0] C_NOT_PID  = 3'd4;
    localparam logic [COND_W-1:0] C_DT_ZERO  = 3'd5;
    localparam logic [COND_W-1:0] C_DIV_BUSY = 3'd6;
    localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd7;

    // Program addresses.
    localparam logic [STEP_W-1:0] S_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] S_CHK   = 5'd1;
    localparam logic [STEP_W-1:0] S_THR   = 5'd2;
    localparam logic [STEP_W-1:0] S_ERR   = 5'd3;
    localparam logic [STEP_W-1:0] S_MED   = 5'd4;
    localparam logic [STEP_W-1:0] S_INTEG = 5'd5;
    localparam logic [STEP_W-1:0] S_MK    = 5'd6;
    localparam logic [STEP_W-1:0] S_MI    = 5'd7;
    localparam logic [STEP_W-1:0] S_DIFF  = 5'd8;
    localparam logic [STEP_W-1:0] S_MD    = 5'd9;
    localparam logic [STEP_W-1:0] S_MM    = 5'd10;
    localparam logic [STEP_W-1:0] S_DIVGO = 5'd11;
    localparam logic [STEP_W-1:0] S_DIVW  = 5'd12;
    localparam logic [STEP_W-1:0] S_ADDQ  = 5'd13;
    localparam logic [STEP_W-1:0] S_SCALE = 5'd14;
    localparam logic [STEP_W-1:0] S_MR    = 5'd15;
    localparam logic [STEP_W-1:0] S_PWM   = 5'd16;
    localparam logic [STEP_W-1:0] S_EMIT  = 5'd17;

    typedef struct packed {
        logic                take;
        logic                emit;
        logic                mul_en;
        logic [SEL_W-1:0]    a_sel;
        logic [SEL_W-1:0]    b_sel;
        logic [ACC_OP_W-1:0] acc_op;
        logic [DP_OP_W-1:0]  dp_op;
        logic [COND_W-1:0]   wait_c;
        logic [COND_W-1:0]   jmp_c;
        logic [STEP_W-1:0]   target;
    } cw_t;

    typedef struct packed {
        logic crit_hit;
        logic not_pid;
        logic dt_zero;
        logic div_busy;
    } dp_stat_t;

    function automatic cw_t mkcw(
        input logic                take,
        input logic                emit,
        input logic                mul_en,
        input logic [SEL_W-1:0]    a_sel,
        input logic [SEL_W-1:0]    b_sel,
        input logic [ACC_OP_W-1:0] acc_op,
        input logic [DP_OP_W-1:0]  dp_op,
        input logic [COND_W-1:0]   wait_c,
        input logic [COND_W-1:0]   jmp_c,
        input logic [STEP_W-1:0]   target
    );
        cw_t w;
        w.take   = take;
        w.emit   = emit;
        w.mul_en = mul_en;
        w.a_sel  = a_sel;
        w.b_sel  = b_sel;
        w.acc_op = acc_op;
        w.dp_op  = dp_op;
        w.wait_c = wait_c;
        w.jmp_c  = jmp_c;
        w.target = target;
        return w;
    endfunction

    // Microcode store. A step stays put while its wait condition holds, then
    // jumps when its jump condition holds, and otherwise falls through.
    function automatic cw_t ucode(input logic [STEP_W-1:0] addr);
        cw_t w;
        unique case (addr)
            S_IDLE:  w = mkcw(1'b1, 1'b0, 1'b0, ASEL_ERR, BSEL_DT, ACC_NONE, DP_NOP,
                              C_NO_IN, C_NEVER, S_IDLE);
            S_CHK:   w = mkcw(1'b0, 1'b0, 1'b0, ASEL_ERR, BSEL_DT, ACC_NONE, DP_CRIT,
                              C_NEVER, C_CRIT, S_EMIT);
            S_THR:   w = mkcw(1'b0, 1'b0, 1'b0, ASEL_ERR, BSEL_DT, ACC_NONE, DP_THR,
                              C_NEVER, C_NOT_PID, S_EMIT);
            S_ERR:   w = mkcw(1'b0, 1'b0, 1'b0, ASEL_ERR, BSEL_DT, ACC_NONE, DP_ERR,
                              C_NEVER, C_NEVER, S_IDLE);
            S_MED:   w = mkcw(1'b0, 1'b0, 1'b1, ASEL_ERR, BSEL_DT, ACC_NONE, DP_NOP,
                              C_NEVER, C_NEVER, S_IDLE);
            S_INTEG: w = mkcw(1'b0, 1'b0, 1'b1, ASEL_ERR, BSEL_GP, ACC_NONE, DP_INTEG,
                              C_NEVER, C_NEVER, S_IDLE);
            S_MK:    w = mkcw(1'b0, 1'b0, 1'b1, ASEL_PROD, BSEL_MILLI, ACC_NONE, DP_NOP,
                              C_NEVER, C_NEVER, S_IDLE);
            S_MI:    w = mkcw(1'b0, 1'b0, 1'b1, ASEL_INTEG, BSEL_GI, ACC_LOAD, DP_NOP,
                              C_NEVER, C_NEVER, S_IDLE);
            S_DIFF:  w = mkcw(1'b0, 1'b0, 1'b0, ASEL_ERR, BSEL_DT, ACC_ADD, DP_DIFF,
                              C_NEVER, C_DT_ZERO, S_SCALE);
            S_MD:    w = mkcw(1'b0, 1'b0, 1'b1, ASEL_DIFF, BSEL_GD, ACC_NONE, DP_NOP,
                              C_NEVER, C_NEVER, S_IDLE);
            S_MM:    w = mkcw(1'b0, 1'b0, 1'b1, ASEL_PROD, BSEL_MICRO, ACC_NONE, DP_NOP,
                              C_NEVER, C_NEVER, S_IDLE);
            S_DIVGO: w = mkcw(1'b0, 1'b0, 1'b0, ASEL_ERR, BSEL_DT, ACC_NONE, DP_DIVGO,
                              C_NEVER, C_NEVER, S_IDLE);
            S_DIVW:  w = mkcw(1'b0, 1'b0, 1'b0, ASEL_ERR, BSEL_DT, ACC_NONE, DP_NOP,
                              C_DIV_BUSY, C_NEVER, S_IDLE);
            S_ADDQ:  w = mkcw(1'b0, 1'b0, 1'b0, ASEL_ERR, BSEL_DT, ACC_ADDQ, DP_NOP,
                              C_NEVER, C_NEVER, S_IDLE);
            S_SCALE: w = mkcw(1'b0, 1'b0, 1'b0, ASEL_ERR, BSEL_DT, ACC_NONE, DP_SCALE,
                              C_NEVER, C_NEVER, S_IDLE);
            S_MR:    w = mkcw(1'b0, 1'b0, 1'b1, ASEL_XS, BSEL_RECIP, ACC_NONE, DP_NOP,
                              C_NEVER, C_NEVER, S_IDLE);
            S_PWM:   w = mkcw(1'b0, 1'b0, 1'b0, ASEL_ERR, BSEL_DT, ACC_NONE, DP_PWM,
                              C_NEVER, C_NEVER, S_IDLE);
            S_EMIT:  w = mkcw(1'b0, 1'b1, 1'b0, ASEL_ERR, BSEL_DT, ACC_NONE, DP_NOP,
                              C_OUT_BUSY, C_ALWAYS, S_IDLE);
            default: w = mkcw(1'b0, 1'b0, 1'b0, ASEL_ERR, BSEL_DT, ACC_NONE, DP_NOP,
                              C_NEVER, C_ALWAYS, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/fan_pid_with_threshold_fallback_core.sv -----
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    temperature, now_ms, is_charging, use_pid
// out      output     out_valid / out_ready  fan_pwm, fan_on, critical
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One temperature sample is handled at a time by a microcoded sequence over one
// shared multiplier and a divider that retires two quotient bits per cycle.
// Critical and threshold samples end after their own check; a PID sample waits
// on the derivative division, which it skips when no time has elapsed.
// Reset restores the register defaults and clears the integral, last error and
// last PID time. A stalled output holds the sequence at its final step.
module fan_pid_with_threshold_fallback_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [fpid_pkg::TEMP_W-1:0]     temperature,
    input  logic [fpid_pkg::TIME_W-1:0]            now_ms,
    input  logic                                   is_charging,
    input  logic                                   use_pid,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [fpid_pkg::PWM_W-1:0]             fan_pwm,
    output logic                                   fan_on,
    output logic                                   critical,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fpid_pkg::IDX_W-1:0]             cfg_index,
    input  logic [fpid_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import fpid_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    cw_t               cw;
    dp_stat_t          stat;
    logic [PWM_W-1:0]  res_pwm;
    logic              res_crit;
    logic              out_busy;
    logic              out_load;
    logic              out_valid_reg, out_valid_next;
    logic [PWM_W-1:0]  fan_pwm_reg;
    logic              fan_on_reg;
    logic              critical_reg;

    fpid_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .stat     (stat),
        .cw       (cw)
    );

    fpid_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cw          (cw),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .temperature (temperature),
        .now_ms      (now_ms),
        .is_charging (is_charging),
        .use_pid     (use_pid),
        .stat        (stat),
        .res_pwm     (res_pwm),
        .res_crit    (res_crit)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TARGET:    cfg_next.target  = cfg_data[TEMP_W-1:0];
                REG_GAIN_P:    cfg_next.gain_p  = cfg_data[GAIN_W-1:0];
                REG_GAIN_I:    cfg_next.gain_i  = cfg_data[GAIN_W-1:0];
                REG_GAIN_D:    cfg_next.gain_d  = cfg_data[GAIN_W-1:0];
                REG_CHG_THR:   cfg_next.chg_thr = cfg_data[TEMP_W-1:0];
                REG_DIS_THR:   cfg_next.dis_thr = cfg_data[TEMP_W-1:0];
                REG_CRIT_TEMP: cfg_next.crit    = cfg_data[TEMP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_busy = out_valid_reg && !out_ready;
    assign out_load = cw.emit && !out_busy;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            fan_pwm_reg  <= res_pwm;
            fan_on_reg   <= (res_pwm != PWM_OFF);
            critical_reg <= res_crit;
        end
    end

    assign in_ready  = cw.take;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign fan_pwm   = fan_pwm_reg;
    assign fan_on    = fan_on_reg;
    assign critical  = critical_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new sample taken while the previous one is in work");

    a_fan_on_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fan_on == (fan_pwm != PWM_OFF)))
        else $error("fan_on disagrees with the duty");

    a_critical_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && critical) |-> (fan_pwm == PWM_FULL))
        else $error("critical transaction without full duty");

endmodule

// ----- rtl/fpid_div.sv -----
module fpid_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  logic signed [fpid_pkg::ACC_W-1:0]  num,
    input  logic [fpid_pkg::TIME_W-1:0]        den,
    output logic                               busy,
    output logic signed [fpid_pkg::ACC_W-1:0]  quo
);
    import fpid_pkg::*;

    localparam int ITER  = DIV_W / 2;
    localparam int CNT_W = $clog2(ITER);

    logic                busy_reg, busy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]    q_reg, q_next;
    logic                neg_reg, neg_next;
    logic [ACC_W-1:0]    mag_full;
    logic [TIME_W-1:0]   rem_mid;
    logic [DIV_W-1:0]    q_mid;
    logic [ACC_W-1:0]    q_ext;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [TIME_W+DIV_W-1:0] div_step(
        input logic [TIME_W-1:0] r,
        input logic [DIV_W-1:0]  q,
        input logic [TIME_W-1:0] d
    );
        logic [TIME_W:0]    trial;
        logic [DIV_W-1:0]   q_o;
        trial = {r, q[DIV_W-1]};
        q_o   = {q[DIV_W-2:0], 1'b0};
        if (trial >= {1'b0, d})
        begin
            trial  = trial - {1'b0, d};
            q_o[0] = 1'b1;
        end
        return {trial[TIME_W-1:0], q_o};
    endfunction

    assign mag_full = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        {rem_mid, q_mid} = div_step(rem_reg, q_reg, den);
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ITER - 1);
            rem_next  = '0;
            q_next    = mag_full[DIV_W-1:0];
            neg_next  = num[ACC_W-1];
        end
        else if (busy_reg)
        begin
            {rem_next, q_next} = div_step(rem_mid, q_mid, den);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    assign q_ext = {{(ACC_W-DIV_W){1'b0}}, q_reg};
    assign quo   = neg_reg ? -$signed(q_ext) : $signed(q_ext);
    assign busy  = busy_reg;

endmodule

// ----- rtl/fpid_dp.sv -----
module fpid_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fpid_pkg::cw_t                      cw,
    input  fpid_pkg::cfg_t                     cfg,
    input  logic                               in_valid,
    input  logic signed [fpid_pkg::TEMP_W-1:0] temperature,
    input  logic [fpid_pkg::TIME_W-1:0]        now_ms,
    input  logic                               is_charging,
    input  logic                               use_pid,
    output fpid_pkg::dp_stat_t                 stat,
    output logic [fpid_pkg::PWM_W-1:0]         res_pwm,
    output logic                               res_crit
);
    import fpid_pkg::*;

    localparam int SUM_W = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(INTEG_LIMIT);
    localparam logic signed [SUM_W-1:0] LIM_LO = -LIM_HI;

    logic signed [TEMP_W-1:0]  temp_reg;
    logic [TIME_W-1:0]         now_reg;
    logic                      chg_reg;
    logic                      pid_reg;
    logic signed [TEMP_W-1:0]  err_reg, err_next;
    logic [TIME_W-1:0]         dt_reg, dt_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [XS_W-1:0]           xs_reg, xs_next;
    logic                      neg_reg, neg_next;
    logic                      big_reg, big_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [TEMP_W-1:0]  perr_reg, perr_next;
    logic [TIME_W-1:0]         ptime_reg, ptime_next;
    logic [PWM_W-1:0]          pwm_reg, pwm_next;
    logic                      crit_reg, crit_next;

    logic signed [DIFF_W-1:0]          raw_err;
    logic signed [TEMP_W-1:0]          err_sat;
    logic signed [MUL_A_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_full;
    logic signed [SUM_W-1:0]           integ_sum;
    logic signed [INTEG_W-1:0]         integ_clamp;
    logic signed [TEMP_W-1:0]          thr;
    logic [ACC_W-SCALE_SHIFT-1:0]      scaled;
    logic                              div_go;
    logic                              div_busy;
    logic signed [ACC_W-1:0]           quo;

    fpid_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (prod_reg),
        .den   (dt_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    assign div_go = (cw.dp_op == DP_DIVGO);

    // Error against the setpoint, saturated to the 13-bit range.
    always_comb
    begin
        raw_err = DIFF_W'(temp_reg) - DIFF_W'($signed(cfg.target));
        if (raw_err[DIFF_W-1] != raw_err[DIFF_W-2])
        begin
            err_sat = raw_err[DIFF_W-1] ? ERR_MIN : ERR_MAX;
        end
        else
        begin
            err_sat = raw_err[TEMP_W-1:0];
        end
    end

    always_comb
    begin
        integ_sum = SUM_W'(prod_reg) + SUM_W'(integ_reg);
        if (integ_sum > LIM_HI)
        begin
            integ_clamp = INTEG_LIMIT;
        end
        else if (integ_sum < LIM_LO)
        begin
            integ_clamp = -INTEG_LIMIT;
        end
        else
        begin
            integ_clamp = integ_sum[INTEG_W-1:0];
        end
    end

    always_comb
    begin
        unique case (cw.a_sel)
            ASEL_ERR:   mul_a = MUL_A_W'(err_reg);
            ASEL_PROD:  mul_a = prod_reg[MUL_A_W-1:0];
            ASEL_INTEG: mul_a = MUL_A_W'(integ_reg);
            ASEL_DIFF:  mul_a = MUL_A_W'(diff_reg);
            ASEL_XS:    mul_a = MUL_A_W'(xs_reg);
            default:    mul_a = '0;
        endcase
        unique case (cw.b_sel)
            BSEL_DT:    mul_b = MUL_B_W'(dt_reg);
            BSEL_GP:    mul_b = MUL_B_W'(cfg.gain_p);
            BSEL_GI:    mul_b = MUL_B_W'(cfg.gain_i);
            BSEL_GD:    mul_b = MUL_B_W'(cfg.gain_d);
            BSEL_MILLI: mul_b = K_MILLI;
            BSEL_MICRO: mul_b = K_MICRO;
            BSEL_RECIP: mul_b = K_RECIP;
            default:    mul_b = '0;
        endcase
        mul_full = mul_a * mul_b;
    end

    assign prod_next = cw.mul_en ? mul_full[PROD_W-1:0] : prod_reg;
    assign thr       = chg_reg ? $signed(cfg.chg_thr) : $signed(cfg.dis_thr);
    assign scaled    = acc_reg[ACC_W-1:SCALE_SHIFT];

    always_comb
    begin
        unique case (cw.acc_op)
            ACC_NONE: acc_next = acc_reg;
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            ACC_ADDQ: acc_next = acc_reg + quo;
            default:  acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        err_next   = err_reg;
        dt_next    = dt_reg;
        diff_next  = diff_reg;
        xs_next    = xs_reg;
        neg_next   = neg_reg;
        big_next   = big_reg;
        integ_next = integ_reg;
        perr_next  = perr_reg;
        ptime_next = ptime_reg;
        pwm_next   = pwm_reg;
        crit_next  = crit_reg;
        unique case (cw.dp_op)
            DP_CRIT:
            begin
                pwm_next  = PWM_FULL;
                crit_next = 1'b1;
            end
            DP_THR:
            begin
                pwm_next  = (temp_reg > thr) ? PWM_FULL : PWM_OFF;
                crit_next = 1'b0;
            end
            DP_ERR:
            begin
                err_next = err_sat;
                dt_next  = now_reg - ptime_reg;
            end
            DP_INTEG:
            begin
                integ_next = integ_clamp;
                ptime_next = now_reg;
            end
            DP_DIFF:
            begin
                diff_next = DIFF_W'(err_reg) - DIFF_W'(perr_reg);
                perr_next = err_reg;
            end
            DP_SCALE:
            begin
                // Negative sums truncate to zero or below, so they give zero duty.
                neg_next = acc_reg[ACC_W-1];
                big_next = !acc_reg[ACC_W-1] && (scaled >= SCALED_FULL);
                xs_next  = acc_reg[SCALE_SHIFT+XS_W-1:SCALE_SHIFT];
            end
            DP_PWM:
            begin
                if (neg_reg)
                begin
                    pwm_next = PWM_OFF;
                end
                else if (big_reg)
                begin
                    pwm_next = PWM_FULL;
                end
                else
                begin
                    pwm_next = prod_reg[RECIP_SHIFT+PWM_W-1:RECIP_SHIFT];
                end
                crit_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            perr_reg  <= '0;
            ptime_reg <= '0;
            pwm_reg   <= PWM_OFF;
            crit_reg  <= 1'b0;
        end
        else
        begin
            integ_reg <= integ_next;
            perr_reg  <= perr_next;
            ptime_reg <= ptime_next;
            pwm_reg   <= pwm_next;
            crit_reg  <= crit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.take && in_valid)
        begin
            temp_reg <= temperature;
            now_reg  <= now_ms;
            chg_reg  <= is_charging;
            pid_reg  <= use_pid;
        end
        err_reg  <= err_next;
        dt_reg   <= dt_next;
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        xs_reg   <= xs_next;
        neg_reg  <= neg_next;
        big_reg  <= big_next;
    end

    assign stat.crit_hit = (temp_reg > $signed(cfg.crit));
    assign stat.not_pid  = !pid_reg;
    assign stat.dt_zero  = (dt_reg == '0);
    assign stat.div_busy = div_busy;
    assign res_pwm       = pwm_reg;
    assign res_crit      = crit_reg;

    a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= INTEG_LIMIT) && (integ_reg >= -INTEG_LIMIT))
        else $error("integral left its anti-windup range");

    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_go |-> !div_busy)
        else $error("divider started while still busy");

    a_crit_full: assert property (@(posedge clk) disable iff (!rst_n)
        crit_reg |-> (pwm_reg == PWM_FULL))
        else $error("critical result without full duty");

endmodule

// ----- rtl/fpid_seq.sv -----
module fpid_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_busy,
    input  fpid_pkg::dp_stat_t stat,
    output fpid_pkg::cw_t      cw
);
    import fpid_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              hold;
    logic              jump;

    function automatic logic cond_true(
        input logic [COND_W-1:0] c,
        input logic              inv,
        input logic              obusy,
        input dp_stat_t          s
    );
        logic r;
        unique case (c)
            C_NEVER:    r = 1'b0;
            C_ALWAYS:   r = 1'b1;
            C_NO_IN:    r = !inv;
            C_CRIT:     r = s.crit_hit;
            C_NOT_PID:  r = s.not_pid;
            C_DT_ZERO:  r = s.dt_zero;
            C_DIV_BUSY: r = s.div_busy;
            C_OUT_BUSY: r = obusy;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    assign cw = ucode(step_reg);

    always_comb
    begin
        hold = cond_true(cw.wait_c, in_valid, out_busy, stat);
        jump = cond_true(cw.jmp_c, in_valid, out_busy, stat);
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (jump)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
